// ===== sv/itr_pkg.sv =====
// itr_pkg: shared types, constants and helpers for the integer to radix text block
// used by itr_front, itr_back, itr_outq and the top level; depends on nothing
`default_nettype none

package itr_pkg;

  // operand width and derived widths
  localparam int VALUE_WIDTH = 32;
  localparam int BASE_W      = 8;
  localparam int CH_W        = 7;
  localparam int DIGIT_W     = 4;
  localparam int RADIX_W     = 5;
  localparam int LG_W        = 3;

  // divider takes this many dividend bits per cycle
  localparam int DIV_BITS  = 8;
  localparam int DIV_STEPS = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
  localparam int DIV_W     = DIV_STEPS * DIV_BITS;
  localparam int STEP_W    = $clog2(DIV_STEPS + 1);

  // digit stack: at most VALUE_WIDTH digits (radix two)
  localparam int STACK_AW = $clog2(VALUE_WIDTH);
  localparam int NDIG_W   = $clog2(VALUE_WIDTH + 1);

  // radix codes
  localparam logic [BASE_W-1:0] BASE_MIN = BASE_W'(2);
  localparam logic [BASE_W-1:0] BASE_MAX = BASE_W'(16);
  localparam logic [BASE_W-1:0] BASE_DEC = BASE_W'(10);
  localparam logic [BASE_W-1:0] BASE_B4  = BASE_W'(4);
  localparam logic [BASE_W-1:0] BASE_B8  = BASE_W'(8);

  // mode codes
  localparam logic FUNC_UNSIGNED = 1'b0;
  localparam logic FUNC_SIGNED   = 1'b1;

  // characters
  localparam logic [CH_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [CH_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CH_W-1:0] CH_ALPHA = 7'h41;
  localparam logic [CH_W-1:0] CH_NONE  = 7'h00;

  // classified work for the back end
  typedef struct packed {
    logic                   bad;
    logic                   neg;
    logic                   pow2;
    logic [LG_W-1:0]        lg;
    logic [RADIX_W-1:0]     radix;
    logic [VALUE_WIDTH-1:0] mag;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            last;
    logic            empty_res;
  } res_t;

  // digit value to ascii, 0-9 then A-F
  function automatic logic [CH_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [CH_W-1:0] c;
    if (d < DIGIT_W'(10)) begin
      c = CH_ZERO + CH_W'(d);
    end else begin
      c = CH_ALPHA + CH_W'(d - DIGIT_W'(10));
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== sv/integer_to_radix_text.sv =====
// integer_to_radix_text: top level, front classifier, digit engine and result queue
// depends on itr_pkg, itr_front, itr_back, itr_outq
`default_nettype none

// Converts a 32-bit value to ASCII text in radix 2 to 16, most significant digit first,
// one character per result transaction with last marking the final one. In signed mode
// with radix 10 a negative value yields a leading '-'. An invalid radix yields one result
// with empty_res set. Up to two items queue at the input and two results at the output.
// Each digit is divided out by the shared divider, which retires 8 dividend bits per cycle,
// in radices that are not a power of two, and by a shift in radix 2, 4, 8 and 16.
// Playback from the digit stack then gives one character per cycle while the result queue
// is not full. One item is converted at a time.
module integer_to_radix_text (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic                            func_i,
  input  wire logic [itr_pkg::VALUE_WIDTH-1:0] value_i,
  input  wire logic [itr_pkg::BASE_W-1:0]      base_i,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic [itr_pkg::CH_W-1:0]             ch_o,
  output logic                                 last_o,
  output logic                                 empty_res_o
);

  itr_pkg::cmd_t cmd;
  itr_pkg::res_t res_in, res_out;
  logic          cmd_valid, cmd_take, res_push, res_full;

  // front: accept and classify
  itr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .func_i      (func_i),
    .value_i     (value_i),
    .base_i      (base_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_take_i  (cmd_take)
  );

  // back: digit generation and playback
  itr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_take_o  (cmd_take),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .res_full_i  (res_full)
  );

  // result queue
  itr_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_push_i (res_push),
    .res_i      (res_in),
    .res_full_o (res_full),
    .empty      (empty),
    .pop        (pop),
    .res_o      (res_out)
  );

  assign ch_o        = res_out.ch;
  assign last_o      = res_out.last;
  assign empty_res_o = res_out.empty_res;

endmodule

`default_nettype wire

// ===== sv/itr_front.sv =====
// itr_front: accepts input transactions, classifies radix and sign, queues the work
// depends on itr_pkg
`default_nettype none

module itr_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           push,
  output logic                                full,
  input  wire logic                           func_i,
  input  wire logic [itr_pkg::VALUE_WIDTH-1:0] value_i,
  input  wire logic [itr_pkg::BASE_W-1:0]     base_i,
  output logic                                cmd_valid_o,
  output itr_pkg::cmd_t                       cmd_o,
  input  wire logic                           cmd_take_i
);

  itr_pkg::cmd_t cls;
  itr_pkg::cmd_t q_mem [2];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;
  logic          do_push, do_pop;

  // classify the incoming transaction
  always_comb begin
    cls       = '0;
    cls.bad   = (base_i < itr_pkg::BASE_MIN) || (base_i > itr_pkg::BASE_MAX);
    cls.neg   = (func_i == itr_pkg::FUNC_SIGNED) && (base_i == itr_pkg::BASE_DEC) &&
                value_i[itr_pkg::VALUE_WIDTH-1];
    cls.mag   = cls.neg ? (~value_i + itr_pkg::VALUE_WIDTH'(1)) : value_i;
    cls.radix = base_i[itr_pkg::RADIX_W-1:0];
    cls.pow2  = 1'b1;
    case (base_i)
      itr_pkg::BASE_MIN: cls.lg = itr_pkg::LG_W'(1);
      itr_pkg::BASE_B4:  cls.lg = itr_pkg::LG_W'(2);
      itr_pkg::BASE_B8:  cls.lg = itr_pkg::LG_W'(3);
      itr_pkg::BASE_MAX: cls.lg = itr_pkg::LG_W'(4);
      default: begin
        cls.lg   = '0;
        cls.pow2 = 1'b0;
      end
    endcase
  end

  assign full        = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem[rd_q];
  assign do_push     = push && !full;
  assign do_pop      = cmd_take_i && cmd_valid_o;

  // two-entry work queue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  // queue payload, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wr_q] <= cls;
    end
  end

endmodule

`default_nettype wire

// ===== sv/itr_back.sv =====
// itr_back: digit engine; divides out digits into a stack, then plays them back msd first
// depends on itr_pkg
`default_nettype none

module itr_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  input  wire itr_pkg::cmd_t cmd_i,
  output logic               cmd_take_o,
  output logic               res_push_o,
  output itr_pkg::res_t      res_o,
  input  wire logic          res_full_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BAD,
    ST_DIV,
    ST_SIGN,
    ST_RD,
    ST_OUT
  } state_e;

  state_e                          state_q;
  logic [itr_pkg::DIV_W-1:0]       dv_q, dv_d;
  logic [itr_pkg::RADIX_W-1:0]     rem_q, rem_d;
  logic [itr_pkg::RADIX_W-1:0]     radix_q;
  logic [itr_pkg::LG_W-1:0]        lg_q;
  logic                            pow2_q, neg_q;
  logic [itr_pkg::STEP_W-1:0]      step_q;
  logic [itr_pkg::NDIG_W-1:0]      cnt_q, cnt_m1, cnt_m2;
  logic [itr_pkg::DIGIT_W-1:0]     stack [itr_pkg::VALUE_WIDTH];
  logic [itr_pkg::DIGIT_W-1:0]     rd_data_q, digit;
  logic [itr_pkg::STACK_AW-1:0]    rd_addr;
  logic                            digit_done, res_want;

  // eight restoring steps of the radix division per cycle, or a shift in power-of-two radices
  always_comb begin
    logic [itr_pkg::DIV_BITS-1:0]  top, qb;
    logic [itr_pkg::RADIX_W:0]     t;
    logic [itr_pkg::RADIX_W-1:0]   r;
    top = dv_q[itr_pkg::DIV_W-1 -: itr_pkg::DIV_BITS];
    r   = rem_q;
    qb  = '0;
    for (int i = itr_pkg::DIV_BITS - 1; i >= 0; i--) begin
      t = {r, top[i]};
      if (t >= {1'b0, radix_q}) begin
        t     = t - {1'b0, radix_q};
        qb[i] = 1'b1;
      end
      r = t[itr_pkg::RADIX_W-1:0];
    end
    if (pow2_q) begin
      dv_d  = dv_q >> lg_q;
      rem_d = '0;
      digit = dv_q[itr_pkg::DIGIT_W-1:0] & itr_pkg::DIGIT_W'(radix_q - itr_pkg::RADIX_W'(1));
    end else begin
      dv_d  = (dv_q << itr_pkg::DIV_BITS) | itr_pkg::DIV_W'(qb);
      rem_d = r;
      digit = r[itr_pkg::DIGIT_W-1:0];
    end
  end

  assign digit_done = pow2_q || (step_q == itr_pkg::STEP_W'(itr_pkg::DIV_STEPS - 1));
  assign cnt_m1     = cnt_q - itr_pkg::NDIG_W'(1);
  assign cnt_m2     = cnt_q - itr_pkg::NDIG_W'(2);

  // result side of the engine
  always_comb begin
    res_o    = '0;
    res_want = 1'b0;
    case (state_q)
      ST_BAD: begin
        res_want        = 1'b1;
        res_o.ch        = itr_pkg::CH_NONE;
        res_o.last      = 1'b1;
        res_o.empty_res = 1'b1;
      end
      ST_SIGN: begin
        res_want = 1'b1;
        res_o.ch = itr_pkg::CH_MINUS;
      end
      ST_OUT: begin
        res_want   = 1'b1;
        res_o.ch   = itr_pkg::digit_char(rd_data_q);
        res_o.last = (cnt_q == itr_pkg::NDIG_W'(1));
      end
      default: res_want = 1'b0;
    endcase
  end

  assign res_push_o = res_want && !res_full_i;
  assign cmd_take_o = (state_q == ST_IDLE) && cmd_valid_i;
  assign rd_addr    = (state_q == ST_OUT && res_push_o) ? cnt_m2[itr_pkg::STACK_AW-1:0]
                                                        : cnt_m1[itr_pkg::STACK_AW-1:0];

  // digit stack, registered read
  always_ff @(posedge clk_i) begin
    if (state_q == ST_DIV && digit_done) begin
      stack[cnt_q[itr_pkg::STACK_AW-1:0]] <= digit;
    end
    rd_data_q <= stack[rd_addr];
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      step_q  <= '0;
      neg_q   <= 1'b0;
      pow2_q  <= 1'b0;
      lg_q    <= '0;
      radix_q <= '0;
      rem_q   <= '0;
      dv_q    <= '0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            neg_q   <= cmd_i.neg;
            pow2_q  <= cmd_i.pow2;
            lg_q    <= cmd_i.lg;
            radix_q <= cmd_i.radix;
            dv_q    <= itr_pkg::DIV_W'(cmd_i.mag);
            rem_q   <= '0;
            step_q  <= '0;
            cnt_q   <= '0;
            state_q <= cmd_i.bad ? ST_BAD : ST_DIV;
          end
        end
        ST_BAD: begin
          if (res_push_o) begin
            state_q <= ST_IDLE;
          end
        end
        ST_DIV: begin
          dv_q <= dv_d;
          if (digit_done) begin
            cnt_q  <= cnt_q + itr_pkg::NDIG_W'(1);
            rem_q  <= '0;
            step_q <= '0;
            if (dv_d == '0) begin
              state_q <= neg_q ? ST_SIGN : ST_RD;
            end
          end else begin
            rem_q  <= rem_d;
            step_q <= step_q + itr_pkg::STEP_W'(1);
          end
        end
        ST_SIGN: begin
          if (res_push_o) begin
            state_q <= ST_RD;
          end
        end
        ST_RD: begin
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (res_push_o) begin
            cnt_q <= cnt_m1;
            if (cnt_q == itr_pkg::NDIG_W'(1)) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== sv/itr_outq.sv =====
// itr_outq: two-entry result queue that decouples the digit engine from the consumer
// depends on itr_pkg
`default_nettype none

module itr_outq (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          res_push_i,
  input  wire itr_pkg::res_t res_i,
  output logic               res_full_o,
  output logic               empty,
  input  wire logic          pop,
  output itr_pkg::res_t      res_o
);

  itr_pkg::res_t q_mem [2];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;
  logic          do_push, do_pop;

  assign res_full_o = (cnt_q == 2'd2);
  assign empty      = (cnt_q == 2'd0);
  assign res_o      = q_mem[rd_q];
  assign do_push    = res_push_i && !res_full_o;
  assign do_pop     = pop && !empty;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) begin
        wr_q <= ~wr_q;
      end
      if (do_pop) begin
        rd_q <= ~rd_q;
      end
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem[wr_q] <= res_i;
    end
  end

endmodule

`default_nettype wire

// ===== sv/itr_checker.sv =====
// itr_checker: port-level assertions for integer_to_radix_text, bound to the top level
// depends on itr_pkg
`default_nettype none

module itr_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            push,
  input wire logic                            full,
  input wire logic                            func_i,
  input wire logic [itr_pkg::VALUE_WIDTH-1:0] value_i,
  input wire logic [itr_pkg::BASE_W-1:0]      base_i,
  input wire logic                            empty,
  input wire logic                            pop,
  input wire logic [itr_pkg::CH_W-1:0]        ch_o,
  input wire logic                            last_o,
  input wire logic                            empty_res_o
);

  // an empty result is alone and carries no character
  a_empty_res_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && empty_res_o) |-> (last_o && ch_o == itr_pkg::CH_NONE))
    else $error("empty result malformed");

  // ordinary results carry a sign or a digit character
  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !empty_res_o) |->
      (ch_o == itr_pkg::CH_MINUS ||
       (ch_o >= itr_pkg::CH_ZERO && ch_o <= itr_pkg::CH_ZERO + 7'd9) ||
       (ch_o >= itr_pkg::CH_ALPHA && ch_o <= itr_pkg::CH_ALPHA + 7'd5)))
    else $error("illegal character");

  // a sign is always followed by digits
  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && ch_o == itr_pkg::CH_MINUS) |-> !last_o)
    else $error("sign marked last");

  // a sign is followed by a digit, never by another sign or an empty result
  a_sign_then_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && ch_o == itr_pkg::CH_MINUS) ##1 !empty |->
      (ch_o != itr_pkg::CH_MINUS && !empty_res_o))
    else $error("sign not followed by digit");

  // a waiting result holds while not taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(ch_o) && $stable(last_o) && $stable(empty_res_o)))
    else $error("result changed while stalled");

endmodule

bind integer_to_radix_text itr_checker u_itr_checker (.*);

`default_nettype wire
